// ===== src/heat_stencil_step_top_macros.svh =====
// assertion macros for the heat stencil step block
// used by heat_stencil_step_top, expects clk and rst_n in scope
`ifndef HEAT_STENCIL_STEP_TOP_MACROS_SVH
`define HEAT_STENCIL_STEP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define HSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define HSS_ASSERT_IMPL(lbl, ante, cons)
`define HSS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/hss_pkg.sv =====
// shared types and constants of the heat stencil step block
// no dependencies
package hss_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int ROW_W      = 16;
  localparam int COL_W      = 10;
  localparam int GCOLS_W    = 11;
  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIFF_W     = 34;
  localparam int PROD_W     = 51;
  localparam int ACC_W      = 53;
  localparam int FRAC_SH    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_X    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y    = 2'd3;

  localparam logic [GCOLS_W-1:0] GRID_COLS_RST = 11'd1024;
  localparam logic [ROW_W-1:0]   GRID_ROWS_RST = 16'd512;
  localparam logic [COEF_W-1:0]  COEF_RST      = 16'd6554;
  localparam logic [ROW_W-1:0]   ROWS_MIN      = 16'd3;
  localparam int                 COLS_MIN      = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ROW_W-1:0]           row_t;
  typedef logic [COL_W-1:0]           col_t;
  typedef logic [COEF_W-1:0]          coef_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  typedef struct packed {
    logic    has0;
    logic    has1;
    logic    border;
    row_t    row;
    col_t    col;
    sample_t s;
  } tag_t;

  typedef struct packed {
    logic    valid;
    tag_t    tag;
    sample_t ctr;
    diff_t   dv;
    diff_t   dh;
  } calc_in_t;

  typedef struct packed {
    logic    valid;
    tag_t    tag;
    sample_t value;
  } calc_out_t;

endpackage

// ===== src/hss_in_if.sv =====
// input sample channel of the heat stencil step block
// depends on hss_pkg
interface hss_in_if;
  import hss_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

// ===== src/hss_out_if.sv =====
// result channel of the heat stencil step block
// depends on hss_pkg
interface hss_out_if;
  import hss_pkg::*;

  logic    valid;
  logic    ready;
  sample_t new_value;
  row_t    out_row;
  col_t    out_col;
  logic    last;

  modport source(output valid, output new_value, output out_row, output out_col,
                 output last, input ready);
  modport sink(input valid, input new_value, input out_row, input out_col,
               input last, output ready);
endinterface

// ===== src/hss_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module hss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/hss_calc.sv =====
// stencil arithmetic: coefficient products, rounding and saturation
// depends on hss_pkg
module hss_calc (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  hss_pkg::coef_t    coef_x,
  input  hss_pkg::coef_t    coef_y,
  input  hss_pkg::calc_in_t din,
  output hss_pkg::calc_out_t dout
);
  import hss_pkg::*;

  logic                     s1_valid_r;
  tag_t                     s1_tag_r;
  sample_t                  s1_ctr_r;
  prod_t                    px_r;
  prod_t                    py_r;
  prod_t                    px_nxt;
  prod_t                    py_nxt;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-FRAC_SH-1:0] q;
  sample_t                  sat;
  calc_out_t                dout_r;
  calc_out_t                dout_nxt;

  // products of unsigned coefficients and signed second differences
  always_comb begin
    px_nxt = $signed({{(PROD_W-COEF_W){1'b0}}, coef_x})
           * $signed({{(PROD_W-DIFF_W){din.dv[DIFF_W-1]}}, din.dv});
    py_nxt = $signed({{(PROD_W-COEF_W){1'b0}}, coef_y})
           * $signed({{(PROD_W-DIFF_W){din.dh[DIFF_W-1]}}, din.dh});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r <= din.tag;
      s1_ctr_r <= din.ctr;
      px_r     <= px_nxt;
      py_r     <= py_nxt;
    end
  end

  // round half up at bit 16, then clamp to 32 bits
  always_comb begin
    acc = $signed({{(ACC_W-SAMPLE_W-FRAC_SH){s1_ctr_r[SAMPLE_W-1]}}, s1_ctr_r,
                   {FRAC_SH{1'b0}}})
        + $signed({{(ACC_W-PROD_W){px_r[PROD_W-1]}}, px_r})
        + $signed({{(ACC_W-PROD_W){py_r[PROD_W-1]}}, py_r})
        + $signed(ACC_W'(1) <<< (FRAC_SH - 1));
    q = acc[ACC_W-1:FRAC_SH];
    priority if (!q[ACC_W-FRAC_SH-1] && (|q[ACC_W-FRAC_SH-2:SAMPLE_W-1])) begin
      sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (q[ACC_W-FRAC_SH-1] && !(&q[ACC_W-FRAC_SH-2:SAMPLE_W-1])) begin
      sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat = q[SAMPLE_W-1:0];
    end
    dout_nxt.valid = s1_valid_r;
    dout_nxt.tag   = s1_tag_r;
    dout_nxt.value = s1_tag_r.border ? s1_ctr_r : sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
    if (!rst_n) begin
      dout_r.valid <= 1'b0;
    end
  end

  assign dout = dout_r;

endmodule

// ===== src/heat_stencil_step_top.sv =====
// heat stencil step: one explicit five-point diffusion step over a streamed grid
// depends on hss_pkg, hss_in_if, hss_out_if, hss_ram, hss_calc and the macro header
//
// usage:
//   in_ch carries one grid sample per transaction, row-major. out_ch carries
//   results (new_value, out_row, out_col, last). sample (r,c) releases cell
//   (r-1,c); on the last grid row it also releases (r,c) unchanged, so row 0
//   gives nothing and last-row samples give two results; last marks each
//   sample's final result. cfg_we/cfg_index/cfg_data write grid_cols,
//   grid_rows, coef_x, coef_y; write them only while the block is empty.
// pipeline: stage a, the hss_calc registers, then the output register.
// throughput: one sample per cycle while out_ch is ready, set by one read per
//   line buffer port per cycle; on the last grid row input holds while both
//   result slots wait for the single result port.
// reset: counters return to the grid origin, registers take their defaults,
//   line buffers are not cleared (every entry is written before a result uses it).
// stall: when out_ch is not ready while a result waits, the whole pipeline holds
//   and in_ch.ready drops; nothing is lost or repeated.
`include "heat_stencil_step_top_macros.svh"
module heat_stencil_step_top #(
  parameter int MAX_COLS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  hss_in_if.sink                          in_ch,
  hss_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [hss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hss_pkg::*;

  localparam int AW  = $clog2(MAX_COLS);
  localparam int CNW = (AW + 1 > GCOLS_W) ? AW + 1 : GCOLS_W;
  localparam int XW  = (AW > COL_W) ? AW : COL_W;

  // configuration
  logic [GCOLS_W-1:0] grid_cols_r;
  row_t               grid_rows_r;
  coef_t              coef_x_r;
  coef_t              coef_y_r;

  // position counters
  logic [AW-1:0]  col_count_r;
  row_t           row_count_r;
  logic [CNW-1:0] cols_ext;
  logic [CNW-1:0] cols_eff;
  logic [CNW-1:0] last_col;
  logic [AW-1:0]  c_sel;
  logic [AW-1:0]  c_right;
  logic [XW-1:0]  c_x;
  logic           is_last_col;
  row_t           rows_eff;
  row_t           last_row;
  row_t           r_sel;
  logic           accept;
  logic           adv;

  // stage a, aligned with ram read data
  logic          sa_valid_r;
  tag_t          sa_tag_r;
  logic [AW-1:0] sa_addr_r;
  tag_t          tag_in;
  sample_t       left_r;
  logic [SAMPLE_W-1:0] ctr_rd;
  logic [SAMPLE_W-1:0] right_rd;
  logic [SAMPLE_W-1:0] up_rd;
  logic          two_we;
  calc_in_t      cin;
  calc_out_t     cout;

  // output register, two result slots
  logic    v0_r;
  logic    v1_r;
  sample_t val0_r;
  sample_t s1_r;
  row_t    row0_r;
  row_t    row1_r;
  col_t    col_r;
  logic    out_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= GRID_COLS_RST;
      grid_rows_r <= GRID_ROWS_RST;
      coef_x_r    <= COEF_RST;
      coef_y_r    <= COEF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_COLS: grid_cols_r <= cfg_data[GCOLS_W-1:0];
        CFG_GRID_ROWS: grid_rows_r <= cfg_data[ROW_W-1:0];
        CFG_COEF_X:    coef_x_r    <= cfg_data[COEF_W-1:0];
        CFG_COEF_Y:    coef_y_r    <= cfg_data[COEF_W-1:0];
      endcase
    end
  end

  always_comb begin
    cols_ext = CNW'(grid_cols_r);
    priority if (cols_ext < CNW'(COLS_MIN)) begin
      cols_eff = CNW'(COLS_MIN);
    end else if (cols_ext > CNW'(MAX_COLS)) begin
      cols_eff = CNW'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
    last_col = cols_eff - CNW'(1);
    c_sel    = (CNW'(col_count_r) >= cols_eff) ? last_col[AW-1:0] : col_count_r;
    c_right  = c_sel + AW'(1);
    c_x      = XW'(c_sel);
    is_last_col = (CNW'(c_sel) == last_col);
    rows_eff = (grid_rows_r < ROWS_MIN) ? ROWS_MIN : grid_rows_r;
    last_row = rows_eff - ROW_W'(1);
    r_sel    = (row_count_r >= rows_eff) ? last_row : row_count_r;
  end

  assign adv         = !(v0_r || v1_r) || (out_ch.ready && !(v0_r && v1_r));
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (accept) begin
      if (is_last_col) begin
        col_count_r <= '0;
        row_count_r <= (r_sel == last_row) ? '0 : r_sel + ROW_W'(1);
      end else begin
        col_count_r <= c_sel + AW'(1);
        row_count_r <= r_sel;
      end
    end
  end

  always_comb begin
    tag_in.has0   = (r_sel != '0);
    tag_in.has1   = (r_sel == last_row);
    tag_in.border = (r_sel == ROW_W'(1)) || (c_sel == '0) || is_last_col;
    tag_in.row    = r_sel;
    tag_in.col    = c_x[COL_W-1:0];
    tag_in.s      = in_ch.sample;
  end

  // two copies of the row above give the center and right neighbor for each accepted sample
  hss_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_above_ctr (
    .clk   (clk),
    .we    (accept),
    .waddr (c_sel),
    .wdata (in_ch.sample),
    .re    (accept),
    .raddr (c_sel),
    .rdata (ctr_rd)
  );

  hss_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_above_right (
    .clk   (clk),
    .we    (accept),
    .waddr (c_sel),
    .wdata (in_ch.sample),
    .re    (accept),
    .raddr (c_right),
    .rdata (right_rd)
  );

  assign two_we = sa_valid_r && adv;

  hss_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLS)) u_two_above (
    .clk   (clk),
    .we    (two_we),
    .waddr (sa_addr_r),
    .wdata (ctr_rd),
    .re    (accept),
    .raddr (c_sel),
    .rdata (up_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
      left_r     <= '0;
    end else if (adv) begin
      sa_valid_r <= accept;
      if (sa_valid_r) begin
        left_r <= ctr_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sa_tag_r  <= tag_in;
      sa_addr_r <= c_sel;
    end
  end

  // second differences, down neighbor is the incoming sample
  always_comb begin
    cin.valid = sa_valid_r;
    cin.tag   = sa_tag_r;
    cin.ctr   = ctr_rd;
    cin.dv    = $signed({{(DIFF_W-SAMPLE_W){up_rd[SAMPLE_W-1]}}, up_rd})
              + $signed({{(DIFF_W-SAMPLE_W){sa_tag_r.s[SAMPLE_W-1]}}, sa_tag_r.s})
              - $signed({{(DIFF_W-SAMPLE_W-1){ctr_rd[SAMPLE_W-1]}}, ctr_rd, 1'b0});
    cin.dh    = $signed({{(DIFF_W-SAMPLE_W){left_r[SAMPLE_W-1]}}, left_r})
              + $signed({{(DIFF_W-SAMPLE_W){right_rd[SAMPLE_W-1]}}, right_rd})
              - $signed({{(DIFF_W-SAMPLE_W-1){ctr_rd[SAMPLE_W-1]}}, ctr_rd, 1'b0});
  end

  hss_calc u_calc (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .coef_x (coef_x_r),
    .coef_y (coef_y_r),
    .din    (cin),
    .dout   (cout)
  );

  assign out_fire = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (adv) begin
      v0_r <= cout.valid && cout.tag.has0;
      v1_r <= cout.valid && cout.tag.has1;
    end else if (out_fire) begin
      if (v0_r) begin
        v0_r <= 1'b0;
      end else begin
        v1_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val0_r <= cout.value;
      s1_r   <= cout.tag.s;
      row0_r <= cout.tag.row - ROW_W'(1);
      row1_r <= cout.tag.row;
      col_r  <= cout.tag.col;
    end
  end

  assign out_ch.valid     = v0_r || v1_r;
  assign out_ch.new_value = v0_r ? val0_r : s1_r;
  assign out_ch.out_row   = v0_r ? row0_r : row1_r;
  assign out_ch.out_col   = col_r;
  assign out_ch.last      = !(v0_r && v1_r);

  `HSS_ASSERT_IMPL(a_full_blocks_input, v0_r && v1_r, !in_ch.ready)
  `HSS_ASSERT_IMPL(a_pair_rows_adjacent, v0_r && v1_r, row1_r == row0_r + ROW_W'(1))
  `HSS_ASSERT_NEXT(a_grid_wraps, accept && is_last_col && r_sel == last_row,
                   row_count_r == '0 && col_count_r == '0)

endmodule

// ===== tb/heat_stencil_step_checker.sv =====
`timescale 1ns / 1ps
// checker for heat_stencil_step_top: tracks registers, line buffers and grid position,
// predicts the cells each sample releases and compares every result transaction
// depends on hss_pkg, hss_in_if and hss_out_if
module heat_stencil_step_checker #(
  parameter int MAX_COLS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hss_in_if                              in_mon,
  hss_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [hss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hss_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             cells_owed,
  output int                             cells_checked
);
  import hss_pkg::*;

  localparam longint SAT_HI = 2147483647;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    sample_t value;
    row_t    row;
    col_t    col;
    logic    last;
  } cell_t;

  cell_t              cells_due[$];
  sample_t            line_up [MAX_COLS];
  sample_t            line_up2 [MAX_COLS];
  sample_t            left_ctr;
  int unsigned        at_row;
  int unsigned        at_col;
  logic [GCOLS_W-1:0] cols_set;
  row_t               rows_set;
  coef_t              cx_set;
  coef_t              cy_set;
  int                 err_total = 0;
  int                 seen_total = 0;

  function automatic sample_t diffuse_cell(sample_t ctr, sample_t up, sample_t down,
                                           sample_t lft, sample_t rgt);
    longint dv;
    longint dh;
    longint acc;
    longint q;
    dv  = longint'(up) + longint'(down) - 2 * longint'(ctr);
    dh  = longint'(lft) + longint'(rgt) - 2 * longint'(ctr);
    acc = longint'(ctr) * 65536 + longint'(cx_set) * dv + longint'(cy_set) * dh;
    q   = (acc + 32768) >>> FRAC_SH;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return sample_t'(q[31:0]);
  endfunction

  task automatic take_sample(input sample_t s);
    int unsigned ce;
    int unsigned re;
    int unsigned c;
    int unsigned r;
    sample_t     ctr;
    cell_t       up_cell;
    cell_t       own_cell;
    ce = (cols_set < COLS_MIN) ? COLS_MIN : (cols_set > MAX_COLS) ? MAX_COLS : cols_set;
    re = (rows_set < ROWS_MIN) ? ROWS_MIN : rows_set;
    c  = (at_col < ce) ? at_col : ce - 1;
    r  = (at_row < re) ? at_row : re - 1;
    ctr = line_up[c];
    if (r >= 1) begin
      if (r == 1 || c == 0 || c == ce - 1) begin
        up_cell.value = ctr;
      end else begin
        up_cell.value = diffuse_cell(ctr, line_up2[c], s, left_ctr, line_up[c + 1]);
      end
      up_cell.row  = row_t'(r - 1);
      up_cell.col  = col_t'(c);
      up_cell.last = (r != re - 1);
      cells_due.push_back(up_cell);
    end
    if (r == re - 1) begin
      own_cell.value = s;
      own_cell.row   = row_t'(r);
      own_cell.col   = col_t'(c);
      own_cell.last  = 1'b1;
      cells_due.push_back(own_cell);
    end
    left_ctr    = ctr;
    line_up2[c] = ctr;
    line_up[c]  = s;
    if (c == ce - 1) begin
      at_col = 0;
      at_row = (r == re - 1) ? 0 : r + 1;
    end else begin
      at_col = c + 1;
      at_row = r;
    end
  endtask

  task automatic check_cell();
    cell_t want;
    if (cells_due.size() == 0) begin
      $error("unexpected result transaction: row %0d col %0d value %0d",
             out_mon.out_row, out_mon.out_col, out_mon.new_value);
      err_total++;
    end else begin
      want = cells_due.pop_front();
      seen_total++;
      if (out_mon.new_value !== want.value) begin
        $error("new_value: expected %0d, got %0d", want.value, out_mon.new_value);
        err_total++;
      end
      if (out_mon.out_row !== want.row) begin
        $error("out_row: expected %0d, got %0d", want.row, out_mon.out_row);
        err_total++;
      end
      if (out_mon.out_col !== want.col) begin
        $error("out_col: expected %0d, got %0d", want.col, out_mon.out_col);
        err_total++;
      end
      if (out_mon.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, out_mon.last);
        err_total++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cells_due.delete();
      at_row   = 0;
      at_col   = 0;
      left_ctr = '0;
      cols_set = GRID_COLS_RST;
      rows_set = GRID_ROWS_RST;
      cx_set   = COEF_RST;
      cy_set   = COEF_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_COLS: cols_set = cfg_data[GCOLS_W-1:0];
          CFG_GRID_ROWS: rows_set = cfg_data[ROW_W-1:0];
          CFG_COEF_X:    cx_set   = cfg_data[COEF_W-1:0];
          CFG_COEF_Y:    cy_set   = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) check_cell();
      if (in_mon.valid && in_mon.ready) take_sample(in_mon.sample);
    end
    mismatches    <= err_total;
    cells_owed    <= cells_due.size();
    cells_checked <= seen_total;
  end

endmodule

// ===== tb/heat_stencil_step_top_tb.sv =====
`timescale 1ns / 1ps
// testbench top for heat_stencil_step_top: clock, reset, configuration writes,
// sample stimulus and result back-pressure; checking is in heat_stencil_step_checker
// depends on hss_pkg, hss_in_if, hss_out_if, heat_stencil_step_top and the checker
module heat_stencil_step_top_tb;
  import hss_pkg::*;

  localparam int      MAX_COLS     = 1024;
  localparam int      STALL_LIMIT  = 2000;
  localparam int      DRAIN_CYCLES = 8;
  localparam sample_t S_MAX        = 32'sh7fff_ffff;
  localparam sample_t S_MIN        = 32'sh8000_0000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    send_idle = 6;
  int                    recv_idle = 74;
  int                    mismatches;
  int                    cells_owed;
  int                    cells_checked;
  int                    samples_sent = 0;
  int                    grids_run = 0;
  int                    quiet_cycles = 0;

  hss_in_if  in_ch();
  hss_out_if out_ch();

  heat_stencil_step_top #(
    .MAX_COLS(MAX_COLS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  heat_stencil_step_checker #(
    .MAX_COLS(MAX_COLS)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .cells_owed   (cells_owed),
    .cells_checked(cells_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("heat_stencil_step_top_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(input sample_t v);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    samples_sent++;
  endtask

  // hold the sender until every owed cell is out, then let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (cells_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] cols_w, input logic [15:0] rows_w,
                            input logic [15:0] cx_w, input logic [15:0] cy_w);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_COLS;
    cfg_data  <= cols_w;
    @(posedge clk);
    cfg_index <= CFG_GRID_ROWS;
    cfg_data  <= rows_w;
    @(posedge clk);
    cfg_index <= CFG_COEF_X;
    cfg_data  <= cx_w;
    @(posedge clk);
    cfg_index <= CFG_COEF_Y;
    cfg_data  <= cy_w;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return ($urandom_range(1) == 0) ? sample_t'(0) : sample_t'(-1);
      3, 4, 5: return sample_t'($urandom);
      default: return sample_t'($urandom_range(131071)) - sample_t'(65536);
    endcase
  endfunction

  function automatic coef_t pick_coef();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      default: return coef_t'($urandom);
    endcase
  endfunction

  task automatic run_grid();
    int unsigned cols_n;
    int unsigned rows_n;
    int unsigned cols_e;
    int unsigned rows_e;
    logic [15:0] cols_w;
    case ($urandom_range(9))
      0:       cols_n = $urandom_range(2);
      1, 2:    cols_n = $urandom_range(40, 9);
      default: cols_n = $urandom_range(8, 3);
    endcase
    rows_n = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(6, 3);
    cols_w = 16'($urandom);
    cols_w[GCOLS_W-1:0] = GCOLS_W'(cols_n);
    cols_e = (cols_n < 3) ? 3 : cols_n;
    rows_e = (rows_n < 3) ? 3 : rows_n;
    settle();
    write_regs(cols_w, 16'(rows_n), pick_coef(), pick_coef());
    repeat (cols_e * rows_e) push_sample(pick_sample());
    grids_run++;
  endtask

  // one full-width row, then shrunk to three columns for the remaining rows
  task automatic run_wide_grid();
    coef_t cx;
    coef_t cy;
    cx = pick_coef();
    cy = pick_coef();
    settle();
    write_regs(16'd2047, 16'd3, cx, cy);
    repeat (MAX_COLS) push_sample(pick_sample());
    settle();
    write_regs(16'd3, 16'd3, cx, cy);
    repeat (6) push_sample(pick_sample());
    grids_run++;
  endtask

  initial begin
    sample_t tie_grid [9];
    int      small_items;
    int      mark;
    logic    wide_done;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_GRID_COLS;
    cfg_data     <= '0;
    rst_n        <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // checkerboard of extremes at full coefficients, then both counters past a shrunk grid
    write_regs(16'd5, 16'hffff, 16'hffff, 16'hffff);
    for (int k = 0; k < 19; k++) begin
      push_sample((((k / 5) + (k % 5)) % 2 != 0) ? S_MIN : S_MAX);
    end
    settle();
    write_regs(16'd3, 16'd2, 16'hffff, 16'hffff);
    push_sample(S_MIN);
    grids_run++;

    // clamped sizes, junk above the column field, half-way rounding
    tie_grid = '{S_MAX, sample_t'(0), S_MIN,
                 sample_t'(0), sample_t'(1), sample_t'(-1),
                 sample_t'(-1), sample_t'(5), sample_t'(1)};
    settle();
    write_regs(16'hf802, 16'd0, 16'd0, 16'h8000);
    foreach (tie_grid[k]) push_sample(tie_grid[k]);
    grids_run++;

    small_items = 0;
    wide_done   = 1'b0;
    while (small_items < 900) begin
      if (small_items < 300) begin
        send_idle = 6;
        recv_idle = 74;
      end else if (small_items < 600) begin
        send_idle = 74;
        recv_idle = 6;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (!wide_done && small_items >= 400) begin
        run_wide_grid();
        wide_done = 1'b1;
      end else begin
        mark = samples_sent;
        run_grid();
        small_items += samples_sent - mark;
      end
    end

    settle();
    $display("%0d samples over %0d grids, %0d result transactions checked",
             samples_sent, grids_run, cells_checked);
    $display("sizes from clamped minimum to full line width, coefficients at both ends");
    if (mismatches == 0) begin
      $display("heat_stencil_step_top_tb: clean");
    end else begin
      $display("heat_stencil_step_top_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/hss_pkg.sv
src/hss_in_if.sv
src/hss_out_if.sv
src/hss_ram.sv
src/hss_calc.sv
src/heat_stencil_step_top.sv
tb/heat_stencil_step_checker.sv
tb/heat_stencil_step_top_tb.sv
